### rtl/ltw_pkg.sv
// shared types, constants and tables of the lanczos tap weight generator
// depends on nothing; used by every rtl file of the block
package ltw_pkg;

  // tap budget of the kernel; the order is capped so that 2a + 1 fits
  localparam int MAX_TAPS = 16;
  localparam int A_RAW    = (MAX_TAPS - 1) / 2;
  localparam int A_CAP    = (A_RAW > 5) ? 5 : A_RAW;

  // register indexes of the configuration port
  localparam logic [1:0] REG_HALF_TAPS = 2'd0;
  localparam logic [1:0] REG_DEN       = 2'd1;
  localparam logic [1:0] REG_SW        = 2'd2;

  // pi^2 in q16 and sine series coefficients in q28
  localparam logic [19:0] PI2_Q16 = 20'd646814;
  localparam logic [28:0] SIN_C1  = 29'd421657428;
  localparam logic [28:0] SIN_C3  = 29'd173399667;
  localparam logic [28:0] SIN_C5  = 29'd21392326;
  localparam logic [28:0] SIN_C7  = 29'd1256749;
  localparam logic [28:0] SIN_C9  = 29'd43068;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [15:0] W_MAX   = 16'sd32767;
  localparam logic signed [15:0] W_MIN   = -16'sd32768;

  typedef struct packed {
    logic [2:0]  half_taps;
    logic [15:0] den;
    logic [15:0] sw;
  } cfg_t;

  // one classified position: tap range and fraction
  typedef struct packed {
    logic [15:0]        first_index;
    logic [15:0]        f16;
    logic [2:0]         a;
    logic signed [3:0]  i_lo;
    logic signed [3:0]  i_hi;
  } job_t;

  typedef struct packed {
    logic [15:0]        first_index;
    logic signed [15:0] weight;
    logic               last_tap;
  } res_t;

  // reciprocal ceil(2^31 / a) for the phase divide
  function automatic logic [31:0] rcp(input logic [2:0] a);
    logic [31:0] r;
    case (a)
      3'd1:    r = 32'd2147483648;
      3'd2:    r = 32'd1073741824;
      3'd3:    r = 32'd715827883;
      3'd4:    r = 32'd536870912;
      3'd5:    r = 32'd429496730;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  // horner coefficient after the top term, in evaluation order
  function automatic logic [28:0] horner_coef(input logic [1:0] k);
    logic [28:0] c;
    case (k)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

### rtl/ltw_front.sv
// front end: accepts a position, divides by the denominator, classifies taps
// depends on ltw_pkg (cfg_t, job_t, A_CAP)
module ltw_front (
  input  logic               clk,
  input  logic               rst,
  input  ltw_pkg::cfg_t      cfg,
  input  logic               push,
  input  logic [31:0]        position_numerator,
  output logic               full,
  output logic               q_push,
  output ltw_pkg::job_t      q_job,
  input  logic               q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [47:0] quo;
  logic [16:0] r;
  logic [15:0] den_r;

  logic [16:0] r_sh;
  logic        q_bit;
  logic [31:0] centre;
  logic [2:0]  a_c;
  logic signed [3:0]  lo;
  logic signed [3:0]  hi;
  logic signed [33:0] hr;
  logic        no_taps;

  assign full = (state != F_IDLE);

  // long division step, 32 integer bits then 16 fraction bits
  always_comb begin
    r_sh  = {r[15:0], dvd[47]};
    q_bit = (r_sh >= {1'b0, den_r});
  end

  // tap range clipped to the source
  always_comb begin
    centre = quo[47:16];
    if (cfg.half_taps < 3'd1) a_c = 3'd1;
    else if (cfg.half_taps > 3'd5) a_c = 3'd5;
    else a_c = cfg.half_taps;
    if (a_c > 3'(ltw_pkg::A_CAP)) a_c = 3'(ltw_pkg::A_CAP);
    if (centre >= {29'd0, a_c - 3'd1}) lo = 4'sd1 - $signed({1'b0, a_c});
    else lo = 4'sd0 - $signed(centre[3:0]);
    hr = $signed({18'd0, cfg.sw}) - 34'sd1 - $signed({2'd0, centre});
    if (hr > $signed({31'd0, a_c})) hi = $signed({1'b0, a_c});
    else hi = hr[3:0];
    no_taps = (hr < 34'(lo)) || (ltw_pkg::A_CAP < 1);
    q_job.first_index = centre[15:0] + {{12{lo[3]}}, lo};
    q_job.f16         = quo[15:0];
    q_job.a           = a_c;
    q_job.i_lo        = lo;
    q_job.i_hi        = hi;
    q_push = (state == F_CLS) && !no_taps && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_DIV;
            cnt   <= 6'd0;
            dvd   <= {position_numerator, 16'd0};
            quo   <= 48'd0;
            r     <= 17'd0;
            den_r <= (cfg.den == 16'd0) ? 16'd1 : cfg.den;
          end
        end
        F_DIV: begin
          r   <= q_bit ? (r_sh - {1'b0, den_r}) : r_sh;
          quo <= {quo[46:0], q_bit};
          dvd <= {dvd[46:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) state <= F_CLS;
        end
        F_CLS: begin
          if (no_taps || !q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/ltw_job_queue.sv
// two-entry queue of classified positions between front and back
// depends on ltw_pkg (job_t)
module ltw_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ltw_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ltw_pkg::job_t head
);

  logic [1:0]    cnt;
  ltw_pkg::job_t e0;
  ltw_pkg::job_t e1;
  logic          push_ok;
  logic          pop_ok;
  logic [1:0]    wpos;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign head    = e0;
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;
  assign wpos    = cnt - {1'b0, pop_ok};

  // entries shift toward the head on a pop
  always_ff @(posedge clk) begin
    if (push_ok && (wpos == 2'd0)) e0 <= din;
    else if (pop_ok) e0 <= e1;
    if (push_ok && (wpos != 2'd0)) e1 <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

### rtl/ltw_back.sv
// back end: sequences one shared multiplier over sines, denominator and divide
// per tap, and holds a two-entry result buffer; depends on ltw_pkg
module ltw_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  ltw_pkg::job_t job,
  output logic          job_pop,
  output logic          empty,
  input  logic          pop,
  output ltw_pkg::res_t res
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_TAP  = 4'd1;
  localparam logic [3:0] B_RCP  = 4'd2;
  localparam logic [3:0] B_DIVA = 4'd3;
  localparam logic [3:0] B_SIN0 = 4'd4;
  localparam logic [3:0] B_SZ2  = 4'd5;
  localparam logic [3:0] B_SH   = 4'd6;
  localparam logic [3:0] B_SS   = 4'd7;
  localparam logic [3:0] B_AS1  = 4'd8;
  localparam logic [3:0] B_AS2  = 4'd9;
  localparam logic [3:0] B_D1   = 4'd10;
  localparam logic [3:0] B_D2   = 4'd11;
  localparam logic [3:0] B_D3   = 4'd12;
  localparam logic [3:0] B_DIV  = 4'd13;
  localparam logic [3:0] B_EMIT = 4'd14;

  logic [3:0]         state;
  logic signed [3:0]  i;
  logic [18:0]        mag;
  logic [26:0]        p1mag;
  logic               p1neg;
  logic [24:0]        ph;
  logic [24:0]        ph2;
  logic               sel;
  logic [28:0]        z;
  logic [1:0]         quad;
  logic [28:0]        z2;
  logic [1:0]         k;
  logic [28:0]        s1mag;
  logic               s1neg;
  logic [28:0]        s2mag;
  logic               s2neg;
  logic [60:0]        num;
  logic [60:0]        rem;
  logic [65:0]        dsh;
  logic [14:0]        q;
  logic [3:0]         cnt;
  logic               nneg;
  logic signed [15:0] w;
  logic [71:0]        prod;

  logic [39:0]        opa;
  logic [31:0]        opb;
  logic signed [20:0] x16;
  logic [18:0]        mag_c;
  logic [23:0]        rf;
  logic [28:0]        z_fold;
  logic [28:0]        z2_new;
  logic [28:0]        t_new;
  logic [27:0]        qe;
  logic [30:0]        qa;
  logic [27:0]        qd;
  logic [27:0]        p2;
  logic [26:0]        p1neg_v;
  logic [51:0]        d_raw;
  logic [51:0]        d;
  logic               sat;
  logic               dbit;
  logic [14:0]        qn;

  logic [1:0]         ocnt;
  ltw_pkg::res_t      o0;
  ltw_pkg::res_t      o1;
  ltw_pkg::res_t      onew;
  logic               o_push;
  logic               o_pop;
  logic [1:0]         owpos;

  // per-tap distance, sine folding, horner terms, phase quotient, denominator and divide step
  always_comb begin
    x16    = $signed({5'd0, job.f16}) - $signed({i[3], i, 16'd0});
    mag_c  = x16[20] ? 19'(-x16) : x16[18:0];
    rf     = ph[23] ? (24'h800000 - {1'b0, ph[22:0]}) : {1'b0, ph[22:0]};
    z_fold = {rf, 5'd0};
    z2_new = prod[56:28];
    t_new  = ltw_pkg::horner_coef(k) - prod[56:28];
    qe     = prod[58:31];
    qa     = qe * job.a;
    qd     = (qa > {4'd0, p1mag}) ? (qe - 28'd1) : qe;
    p2     = p1neg ? (28'd0 - qd) : qd;
    p1neg_v = 27'd0 - p1mag;
    d_raw  = prod[57:6];
    d      = (d_raw == 52'd0) ? 52'd1 : d_raw;
    sat    = ({6'd0, num} >= {d, 15'd0});
    dbit   = ({5'd0, rem} >= dsh);
    qn     = {q[13:0], dbit};
  end

  // operand select of the shared multiplier
  always_comb begin
    opa = 40'd0;
    opb = 32'd0;
    case (state)
      B_RCP: begin
        opa = {13'd0, p1mag};
        opb = ltw_pkg::rcp(job.a);
      end
      B_SIN0: begin
        opa = {11'd0, z_fold};
        opb = {3'd0, z_fold};
      end
      B_SZ2: begin
        opa = {11'd0, z2_new};
        opb = {3'd0, ltw_pkg::SIN_C9};
      end
      B_SH: begin
        opa = (k == 2'd3) ? {11'd0, z} : {11'd0, z2};
        opb = {3'd0, t_new};
      end
      B_AS1: begin
        opa = {11'd0, s1mag};
        opb = {29'd0, job.a};
      end
      B_AS2: begin
        opa = {8'd0, prod[31:0]};
        opb = {3'd0, s2mag};
      end
      B_D1: begin
        opa = {21'd0, mag};
        opb = {12'd0, ltw_pkg::PI2_Q16};
      end
      B_D2: begin
        opa = prod[39:0];
        opb = {13'd0, mag};
      end
      default: begin
        opa = 40'd0;
        opb = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // result beat for the buffer
  always_comb begin
    onew.first_index = job.first_index;
    onew.weight      = w;
    onew.last_tap    = (i == job.i_hi);
    o_push  = (state == B_EMIT) && (ocnt != 2'd2);
    job_pop = o_push && (i == job.i_hi);
    o_pop   = pop && (ocnt != 2'd0);
    owpos   = ocnt - {1'b0, o_pop};
  end

  // tap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            i     <= job.i_lo;
            state <= B_TAP;
          end
        end
        B_TAP: begin
          mag   <= mag_c;
          p1mag <= {mag_c, 8'd0};
          p1neg <= x16[20];
          if (job.f16 == 16'd0) begin
            w     <= (i == 4'sd0) ? ltw_pkg::ONE_Q14 : 16'sd0;
            state <= B_EMIT;
          end else begin
            state <= B_RCP;
          end
        end
        B_RCP: state <= B_DIVA;
        B_DIVA: begin
          ph2   <= p2[24:0];
          ph    <= p1neg ? p1neg_v[24:0] : p1mag[24:0];
          sel   <= 1'b0;
          state <= B_SIN0;
        end
        B_SIN0: begin
          z     <= z_fold;
          quad  <= ph[24:23];
          state <= B_SZ2;
        end
        B_SZ2: begin
          z2    <= z2_new;
          k     <= 2'd0;
          state <= B_SH;
        end
        B_SH: begin
          k <= k + 2'd1;
          if (k == 2'd3) state <= B_SS;
        end
        B_SS: begin
          if (!sel) begin
            s1mag <= prod[56:28];
            s1neg <= quad[1];
            ph    <= ph2;
            sel   <= 1'b1;
            state <= B_SIN0;
          end else begin
            s2mag <= prod[56:28];
            s2neg <= quad[1];
            state <= B_AS1;
          end
        end
        B_AS1: state <= B_AS2;
        B_AS2: state <= B_D1;
        B_D1: begin
          num   <= prod[60:0];
          state <= B_D2;
        end
        B_D2: state <= B_D3;
        B_D3: begin
          nneg <= s1neg ^ s2neg;
          rem  <= num;
          dsh  <= {d, 14'd0};
          q    <= 15'd0;
          cnt  <= 4'd14;
          if (sat) begin
            w     <= (s1neg ^ s2neg) ? ltw_pkg::W_MIN : ltw_pkg::W_MAX;
            state <= B_EMIT;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (dbit) rem <= rem - dsh[60:0];
          q   <= qn;
          dsh <= {1'b0, dsh[65:1]};
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            w     <= nneg ? $signed(16'd0 - {1'b0, qn}) : $signed({1'b0, qn});
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (o_push) begin
            if (i == job.i_hi) begin
              state <= B_IDLE;
            end else begin
              i     <= i + 4'sd1;
              state <= B_TAP;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // result buffer
  assign empty = (ocnt == 2'd0);
  assign res   = o0;

  always_ff @(posedge clk) begin
    if (o_push && (owpos == 2'd0)) o0 <= onew;
    else if (o_pop) o0 <= o1;
    if (o_push && (owpos != 2'd0)) o1 <= onew;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

endmodule

### rtl/lanczos_tap_weight_generator_top.sv
// top level of the lanczos tap weight generator: registers, front, queue, back
// depends on ltw_pkg, ltw_front, ltw_job_queue, ltw_back
//
// Each position pushed in yields one weight beat per source tap that lies in
// range (up to 2a), all carrying the first in-range source index, the last
// one flagged by last_tap. The front runs a bit-serial division of the
// numerator (centre and 16-bit fraction), then classifies the tap range;
// it stays full during that time. A two-entry queue lets it take the next
// position while the back works. The back shares one multiplier among two
// sine evaluations, the phase divide by a, the product of the sines and the
// pi^2 x^2 denominator, then runs a 15-step restoring divide, which a
// saturating weight skips; at integer positions the weight is set directly.
// Results wait in a two-entry buffer. The user must write the registers only
// while the block is idle; the block itself does not enforce this.
module lanczos_tap_weight_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        position_numerator,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        first_index,
  output logic signed [15:0] weight,
  output logic               last_tap
);

  ltw_pkg::cfg_t cfg;
  ltw_pkg::job_t f_job;
  ltw_pkg::job_t q_head;
  ltw_pkg::res_t res;
  logic          q_push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_taps <= 3'd3;
      cfg.den       <= 16'd1;
      cfg.sw        <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        ltw_pkg::REG_HALF_TAPS: cfg.half_taps <= cfg_data[2:0];
        ltw_pkg::REG_DEN:       cfg.den       <= cfg_data;
        ltw_pkg::REG_SW:        cfg.sw        <= cfg_data;
        default: ;
      endcase
    end
  end

  ltw_front u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .push               (push),
    .position_numerator (position_numerator),
    .full               (full),
    .q_push             (q_push),
    .q_job              (f_job),
    .q_full             (q_full)
  );

  ltw_job_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .head  (q_head)
  );

  ltw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign first_index = res.first_index;
  assign weight      = res.weight;
  assign last_tap    = res.last_tap;

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("job popped from an empty queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full) else $error("front not busy after a beat");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("waiting result lost");

endmodule

### verif/lanczos_tap_weight_generator_checker.sv
// checker for the lanczos tap weight generator: tracks the register port,
// predicts the weight beats of each accepted position and compares them
// depends on ltw_pkg for the register indexes and the fixed-point constants
`timescale 1ns / 100ps

module lanczos_tap_weight_generator_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic [31:0]        position_numerator,
  input  logic               empty,
  input  logic               pop,
  input  logic [15:0]        first_index,
  input  logic signed [15:0] weight,
  input  logic               last_tap,
  output int                 fail_count,
  output int                 pending,
  output int                 beats_checked
);

  // shadow copy of the registers
  logic [2:0]  order_reg;
  logic [15:0] den_reg;
  logic [15:0] width_reg;

  ltw_pkg::res_t weight_q[$];

  // sin(pi * p / 2^24) in q28, quarter-wave fold and taylor series
  function automatic longint sine_q28(input longint p);
    longint unsigned u, quad, r, z, z2, t, s;
    u    = longint'(p) & 64'h1FF_FFFF;
    quad = u >> 23;
    r    = u & 64'h7F_FFFF;
    if (quad[0]) r = (64'd1 << 23) - r;
    z  = r << 5;
    z2 = (z * z) >> 28;
    t  = ltw_pkg::SIN_C9;
    t  = ltw_pkg::SIN_C7 - ((z2 * t) >> 28);
    t  = ltw_pkg::SIN_C5 - ((z2 * t) >> 28);
    t  = ltw_pkg::SIN_C3 - ((z2 * t) >> 28);
    t  = ltw_pkg::SIN_C1 - ((z2 * t) >> 28);
    s  = (z * t) >> 28;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // kernel value at signed q16 distance x16, saturated q1.14
  function automatic logic signed [15:0] kernel_q14(input longint x16, input longint a);
    longint s1, s2, w;
    longint unsigned mag, d;
    s1  = sine_q28(x16 * 256);
    s2  = sine_q28((x16 * 256) / a);
    mag = (x16 < 0) ? -x16 : x16;
    d   = (longint'(ltw_pkg::PI2_Q16) * (mag * mag)) >> 6;
    if (d < 1) d = 1;
    w = (a * s1 * s2) / longint'(d);
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    return w[15:0];
  endfunction

  // queue up every beat that one position yields
  task automatic predict_taps(input logic [31:0] num);
    longint unsigned den, centre, rem;
    longint f16, a, i, pt;
    logic [15:0] base;
    ltw_pkg::res_t r;
    int n;
    den    = (den_reg == 0) ? 1 : den_reg;
    centre = num / den;
    rem    = num % den;
    f16    = (rem << 16) / den;
    a      = order_reg;
    n      = 0;
    base   = '0;
    if (a < 1) a = 1;
    if (a > 5) a = 5;
    if (a > ltw_pkg::A_CAP) a = ltw_pkg::A_CAP;
    if (a < 1) return;
    for (i = -a + 1; i <= a; i++) begin
      pt = longint'(centre) + i;
      if (pt < 0 || pt >= longint'(width_reg)) continue;
      if (n == 0) base = pt[15:0];
      r.first_index = base;
      if (rem == 0) r.weight = (i == 0) ? ltw_pkg::ONE_Q14 : 16'sd0;
      else r.weight = kernel_q14(f16 - i * 65536, a);
      r.last_tap = 1'b0;
      weight_q.push_back(r);
      n++;
    end
    if (n > 0) weight_q[weight_q.size() - 1].last_tap = 1'b1;
  endtask

  // watch the three channels
  always @(posedge clk) begin
    ltw_pkg::res_t e;
    if (rst) begin
      order_reg     <= 3'd3;
      den_reg       <= 16'd1;
      width_reg     <= 16'd1;
      weight_q.delete();
      fail_count    <= 0;
      pending       <= 0;
      beats_checked <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ltw_pkg::REG_HALF_TAPS: order_reg <= cfg_data[2:0];
          ltw_pkg::REG_DEN:       den_reg   <= cfg_data;
          ltw_pkg::REG_SW:        width_reg <= cfg_data;
          default: ;
        endcase
      end
      if (push && !full) predict_taps(position_numerator);
      if (pop && !empty) begin
        beats_checked <= beats_checked + 1;
        if (weight_q.size() == 0) begin
          $display("%0t: unexpected beat idx=%0d w=%0d last=%0b",
                   $time, first_index, weight, last_tap);
          fail_count <= fail_count + 1;
        end else begin
          e = weight_q.pop_front();
          if (e.first_index !== first_index || e.weight !== weight
              || e.last_tap !== last_tap) begin
            $display("%0t: mismatch expected idx=%0d w=%0d last=%0b",
                     $time, e.first_index, e.weight, e.last_tap);
            $display("%0t:          actual idx=%0d w=%0d last=%0b",
                     $time, first_index, weight, last_tap);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= weight_q.size();
    end
  end

endmodule

### verif/tb_lanczos_tap_weight_generator_top.sv
// testbench top of the lanczos tap weight generator: clock, reset, stimulus
// depends on ltw_pkg, lanczos_tap_weight_generator_top and the checker module
`timescale 1ns / 100ps

module tb_lanczos_tap_weight_generator_top;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               push;
  logic               full;
  logic [31:0]        position_numerator;
  logic               empty;
  logic               pop;
  logic [15:0]        first_index;
  logic signed [15:0] weight;
  logic               last_tap;

  int fail_count, pending, beats_checked;
  int positions_sent, settings_used;
  logic [15:0] cur_den, cur_width;

  lanczos_tap_weight_generator_top dut (.*);

  lanczos_tap_weight_generator_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("lanczos_tap_weight_generator_top verification failed");
    $finish;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 70);
    return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
  endfunction

  // result side: random stalls with quiet stretches
  initial begin
    int stall;
    bit steady;
    pop = 1'b0;
    stall = 0;
    steady = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // drain and let the back end finish before touching the registers
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] a, input logic [15:0] d, input logic [15:0] w);
    wait_idle();
    write_reg(ltw_pkg::REG_HALF_TAPS, {13'd0, a});
    write_reg(ltw_pkg::REG_DEN, d);
    write_reg(ltw_pkg::REG_SW, w);
    cur_den   = d;
    cur_width = w;
    settings_used++;
  endtask

  // one position beat, then an optional gap
  task automatic send_pos(input logic [31:0] num);
    int g;
    push <= 1'b1;
    position_numerator <= num;
    @(posedge clk);
    while (full) @(posedge clk);
    positions_sent++;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // mostly positions near the source, some on the grid, some anywhere
  function automatic logic [31:0] pick_pos();
    longint unsigned d, c, v;
    int r;
    d = (cur_den == 0) ? 1 : cur_den;
    r = $urandom_range(0, 99);
    if (r >= 85) return $urandom;
    c = $urandom_range(0, int'(cur_width) + 5);
    v = c * d + ((r < 70) ? ($urandom % d) : 0);
    if (v > 64'hFFFF_FFFF) return $urandom;
    return v[31:0];
  endfunction

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = ltw_pkg::REG_HALF_TAPS;
    cfg_data = '0;
    push = 1'b0;
    position_numerator = '0;
    positions_sent = 0;
    settings_used = 1;
    cur_den = 16'd1;
    cur_width = 16'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single source sample
    send_pos(32'd0);
    send_pos(32'd1);
    send_pos(32'hFFFF_FFFF);

    // widest kernel, largest sizes
    set_config(3'd5, 16'hFFFF, 16'hFFFF);
    send_pos(32'd0);
    send_pos(32'hFFFF_FFFF);
    send_pos(32'd65535 * 100 + 1);
    send_pos(32'd65535 * 100 + 32767);
    send_pos(32'd65535 * 100 + 65534);
    send_pos(32'd65535 * 65534 + 40000);

    // order zero acts as one, denominator zero acts as one
    set_config(3'd0, 16'd0, 16'd7);
    send_pos(32'd0);
    send_pos(32'd3);
    send_pos(32'd6);
    send_pos(32'd7);
    send_pos(32'd9);

    // order above five clamps; zero width gives no beats
    set_config(3'd7, 16'd3, 16'd0);
    send_pos(32'd5);
    send_pos(32'd10);

    // quarter fractions
    set_config(3'd2, 16'd4, 16'd30);
    send_pos(32'd5);
    send_pos(32'd6);
    send_pos(32'd7);
    send_pos(32'd120);

    // random settings, random positions
    for (int ph = 0; ph < 6; ph++) begin
      logic [15:0] d, w;
      case ($urandom_range(0, 3))
        0: d = 16'd1;
        1: d = 16'hFFFF;
        2: d = 16'($urandom_range(2, 300));
        default: d = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 4))
        0: w = 16'd1;
        1: w = 16'hFFFF;
        2: w = 16'($urandom_range(1, 65535));
        default: w = 16'($urandom_range(1, 64));
      endcase
      set_config(3'($urandom_range(0, 7)), d, w);
      for (int k = 0; k < 34; k++) send_pos(pick_pos());
    end

    // drain and settle
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("covered %0d positions over %0d register settings, %0d weight beats checked",
             positions_sent, settings_used, beats_checked);
    if (fail_count == 0 && pending == 0)
      $display("lanczos_tap_weight_generator_top verification clean");
    else
      $display("lanczos_tap_weight_generator_top verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/ltw_pkg.sv
rtl/ltw_front.sv
rtl/ltw_job_queue.sv
rtl/ltw_back.sv
rtl/lanczos_tap_weight_generator_top.sv
verif/lanczos_tap_weight_generator_checker.sv
verif/tb_lanczos_tap_weight_generator_top.sv
